### rtl/beacon_duty_vote_classifier_defines.svh
// Assertion macros for the checking file of the beacon duty classifier.
`ifndef BEACON_DUTY_VOTE_CLASSIFIER_DEFINES_SVH
`define BEACON_DUTY_VOTE_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BDV_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bdv check failed");

// Next-cycle implication, disabled during reset.
`define BDV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bdv check failed");

`endif

### rtl/bdv_pkg.sv
package bdv_pkg;

    localparam int FIELD_TIME_BITS = 16;
    localparam int TIMER_BITS_DEF  = 16;
    localparam int CFG_DATA_BITS   = 16;
    localparam int CFG_INDEX_BITS  = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_CLASS_MODE    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BEACON_PERIOD = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_VOTE_TARGET   = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TIMEOUT_TICKS = 2'd3;

    localparam logic        OP_EDGE = 1'b0;
    localparam logic        OP_TICK = 1'b1;
    localparam logic        MODE_THREE = 1'b0;

    localparam logic [15:0] PERIOD_RST  = 16'd150;
    localparam logic [7:0]  TARGET_RST  = 8'd40;
    localparam logic [15:0] TIMEOUT_RST = 16'd50;

    localparam logic [6:0]  DUTY_SCALE    = 7'd100;
    localparam logic [7:0]  DUTY_NONE_MAX = 8'd20;
    localparam logic [7:0]  DUTY_MID_LO   = 8'd40;
    localparam logic [7:0]  DUTY_MID_HI   = 8'd60;
    localparam logic [7:0]  DUTY_CAP      = 8'd80;
    localparam logic [7:0]  DUTY_SAT      = 8'd255;
    localparam logic [6:0]  VERDICT_NONE  = 7'd0;
    localparam logic [6:0]  VERDICT_30    = 7'd30;
    localparam logic [6:0]  VERDICT_50    = 7'd50;
    localparam logic [6:0]  VERDICT_70    = 7'd70;

    typedef struct packed {
        logic        op;
        logic        edge_rising;
        logic [15:0] capture_time;
    } bdv_in_t;

    typedef struct packed {
        logic [6:0] decided_duty;
        logic [7:0] measured_duty;
        logic       verdict_made;
    } bdv_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_VOTE
    } bdv_state_t;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_CHECK,
        DV_STEP
    } bdv_div_state_t;

    function automatic logic [7:0] sat_inc8(input logic [7:0] v);
        logic [7:0] r;
        r = (v == 8'hFF) ? v : v + 8'd1;
        return r;
    endfunction

endpackage

### rtl/bdv_div.sv
module bdv_div
    import bdv_pkg::*;
#(
    parameter int NUM_BITS = TIMER_BITS_DEF + 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_BITS-1:0] dividend,
    input  logic [15:0]         divisor,
    output logic                done,
    output logic [7:0]          quotient
);

    localparam int CMP_BITS = (NUM_BITS > 24) ? NUM_BITS : 24;

    bdv_div_state_t      state_reg, state_next;
    logic [NUM_BITS-1:0] num_reg, num_next;
    logic [15:0]         div_reg, div_next;
    logic [15:0]         rem_reg, rem_next;
    logic [7:0]          low_reg, low_next;
    logic [7:0]          quo_reg, quo_next;
    logic [2:0]          cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [16:0]         trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
    end

    always_comb
    begin
        state_next = state_reg;
        num_next   = num_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        low_next   = low_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        trial      = {rem_reg, low_reg[7]};
        case (state_reg)
            DV_IDLE:
            begin
                if (start)
                begin
                    num_next   = dividend;
                    div_next   = divisor;
                    state_next = DV_CHECK;
                end
            end
            DV_CHECK:
            begin
                // A quotient above 255 saturates; this also covers a zero divisor.
                if (CMP_BITS'(num_reg) >= CMP_BITS'({div_reg, 8'h00}))
                begin
                    quo_next   = DUTY_SAT;
                    done_next  = 1'b1;
                    state_next = DV_IDLE;
                end
                else
                begin
                    rem_next   = 16'(num_reg[NUM_BITS-1:8]);
                    low_next   = num_reg[7:0];
                    cnt_next   = 3'd7;
                    state_next = DV_STEP;
                end
            end
            DV_STEP:
            begin
                if (trial >= {1'b0, div_reg})
                begin
                    rem_next = 16'(trial - {1'b0, div_reg});
                    quo_next = {quo_reg[6:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[15:0];
                    quo_next = {quo_reg[6:0], 1'b0};
                end
                low_next = {low_reg[6:0], 1'b0};
                if (cnt_reg == 3'd0)
                begin
                    done_next  = 1'b1;
                    state_next = DV_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg - 3'd1;
                end
            end
            default:
            begin
                state_next = DV_IDLE;
            end
        endcase
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/beacon_duty_vote_classifier.sv
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid / in_ready | bdv_in_t  (op, edge_rising, capture_time)
// out     | output    | out_valid/out_ready | bdv_out_t (decided_duty, measured_duty,
//         |           |                     |            verdict_made)
// cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// A tick item gives its result in the cycle after its transfer.
// An edge item passes through ST_MUL, ST_DIV_START, ST_DIV_WAIT and ST_VOTE. The
// divider resolves one quotient bit per cycle in eight steps, or none on saturation.
// One item is in work at a time, and a new item is taken only after the result has
// been transferred. Reset is asynchronous, active low, and spares the data registers.
module beacon_duty_vote_classifier
    import bdv_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  bdv_in_t                   in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output bdv_out_t                  out_data,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int STAMP_BITS = (TIMER_BITS < FIELD_TIME_BITS) ? TIMER_BITS : FIELD_TIME_BITS;
    localparam int PROD_BITS  = STAMP_BITS + 7;

    bdv_state_t            state_reg, state_next;
    logic                  class_mode_reg;
    logic [15:0]           period_reg;
    logic [7:0]            target_reg;
    logic [15:0]           timeout_reg;
    logic [STAMP_BITS-1:0] rise_stamp_reg, rise_stamp_next;
    logic [STAMP_BITS-1:0] high_ticks_reg, high_ticks_next;
    logic [7:0]            votes_low_reg, votes_low_next;
    logic [7:0]            votes_high_reg, votes_high_next;
    logic [7:0]            votes_none_reg, votes_none_next;
    logic [6:0]            verdict_reg, verdict_next;
    logic [15:0]           idle_ticks_reg, idle_ticks_next;
    logic [7:0]            last_duty_reg, last_duty_next;
    logic [PROD_BITS-1:0]  product_reg, product_next;
    logic                  out_valid_reg, out_valid_next;
    bdv_out_t              out_data_reg, out_data_next;

    logic                  accept;
    logic                  div_start;
    logic                  div_done;
    logic [7:0]            duty;
    logic [STAMP_BITS-1:0] stamp;
    logic [15:0]           limit;
    logic [7:0]            target;
    logic                  three;
    logic                  made;
    logic [7:0]            vl, vh, vn;

    bdv_div #(
        .NUM_BITS (PROD_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product_reg),
        .divisor  (period_reg),
        .done     (div_done),
        .quotient (duty)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_mode_reg <= MODE_THREE;
            period_reg     <= PERIOD_RST;
            target_reg     <= TARGET_RST;
            timeout_reg    <= TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CLASS_MODE:    class_mode_reg <= cfg_data[0];
                REG_BEACON_PERIOD: period_reg     <= cfg_data;
                REG_VOTE_TARGET:   target_reg     <= cfg_data[7:0];
                REG_TIMEOUT_TICKS: timeout_reg    <= cfg_data;
                default:           timeout_reg    <= timeout_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rise_stamp_reg <= '0;
            high_ticks_reg <= '0;
            votes_low_reg  <= '0;
            votes_high_reg <= '0;
            votes_none_reg <= '0;
            verdict_reg    <= '0;
            idle_ticks_reg <= '0;
            last_duty_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rise_stamp_reg <= rise_stamp_next;
            high_ticks_reg <= high_ticks_next;
            votes_low_reg  <= votes_low_next;
            votes_high_reg <= votes_high_next;
            votes_none_reg <= votes_none_next;
            verdict_reg    <= verdict_next;
            idle_ticks_reg <= idle_ticks_next;
            last_duty_reg  <= last_duty_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        product_reg  <= product_next;
        out_data_reg <= out_data_next;
    end

    assign in_ready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign stamp     = in_data.capture_time[STAMP_BITS-1:0];
    assign limit     = (timeout_reg == 16'd0) ? 16'd1 : timeout_reg;
    assign target    = (target_reg == 8'd0) ? 8'd1 : target_reg;
    assign three     = (class_mode_reg == MODE_THREE);

    always_comb
    begin
        state_next      = state_reg;
        rise_stamp_next = rise_stamp_reg;
        high_ticks_next = high_ticks_reg;
        votes_low_next  = votes_low_reg;
        votes_high_next = votes_high_reg;
        votes_none_next = votes_none_reg;
        verdict_next    = verdict_reg;
        idle_ticks_next = idle_ticks_reg;
        last_duty_next  = last_duty_reg;
        product_next    = product_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;
        div_start       = 1'b0;
        made            = 1'b0;
        vl              = votes_low_reg;
        vh              = votes_high_reg;
        vn              = votes_none_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.op == OP_TICK)
                    begin
                        if (idle_ticks_reg < limit)
                        begin
                            idle_ticks_next = idle_ticks_reg + 16'd1;
                            if (idle_ticks_next >= limit)
                            begin
                                verdict_next = VERDICT_NONE;
                                made         = 1'b1;
                            end
                        end
                        out_valid_next = 1'b1;
                        out_data_next  = '{verdict_next, last_duty_reg, made};
                    end
                    else
                    begin
                        if (in_data.edge_rising)
                        begin
                            rise_stamp_next = stamp;
                        end
                        else if (stamp > rise_stamp_reg)
                        begin
                            high_ticks_next = stamp - rise_stamp_reg;
                        end
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                product_next = PROD_BITS'(high_ticks_reg) * PROD_BITS'(DUTY_SCALE);
                state_next   = ST_DIV_START;
            end
            ST_DIV_START:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_VOTE;
                end
            end
            ST_VOTE:
            begin
                if (three)
                begin
                    if (duty > DUTY_NONE_MAX && duty < DUTY_MID_LO)
                    begin
                        vl = sat_inc8(votes_low_reg);
                    end
                    else if (duty > DUTY_MID_HI && duty < DUTY_CAP)
                    begin
                        vh = sat_inc8(votes_high_reg);
                    end
                    else if (duty < DUTY_CAP)
                    begin
                        vn = sat_inc8(votes_none_reg);
                    end
                end
                else if (duty >= DUTY_MID_LO && duty <= DUTY_MID_HI)
                begin
                    vl = sat_inc8(votes_low_reg);
                end
                else
                begin
                    vn = sat_inc8(votes_none_reg);
                end

                if (vl >= target)
                begin
                    verdict_next = three ? VERDICT_30 : VERDICT_50;
                    made         = 1'b1;
                end
                else if (three && vh >= target)
                begin
                    verdict_next = VERDICT_70;
                    made         = 1'b1;
                end
                else if (vn >= target)
                begin
                    verdict_next = VERDICT_NONE;
                    made         = 1'b1;
                end

                if (made)
                begin
                    votes_low_next  = '0;
                    votes_high_next = '0;
                    votes_none_next = '0;
                end
                else
                begin
                    votes_low_next  = vl;
                    votes_high_next = vh;
                    votes_none_next = vn;
                end
                last_duty_next  = duty;
                idle_ticks_next = '0;
                out_valid_next  = 1'b1;
                out_data_next   = '{verdict_next, duty, made};
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/bdv_chk.sv
`include "beacon_duty_vote_classifier_defines.svh"

module bdv_chk
    import bdv_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_ready,
    input logic     out_valid,
    input logic     out_ready,
    input bdv_out_t out_data
);

    // A stalled result keeps its place and its value.
    `BDV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `BDV_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data))

    // The block never takes an item while a result is still waiting.
    `BDV_ASSERT_IMPL(a_one_in_flight, in_ready, !out_valid)

    // After a transfer in, the block is busy in the next cycle.
    `BDV_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready)

    // The decided duty is always one of the class values.
    `BDV_ASSERT_IMPL(a_duty_class, out_valid,
        out_data.decided_duty == VERDICT_NONE || out_data.decided_duty == VERDICT_30 ||
        out_data.decided_duty == VERDICT_50 || out_data.decided_duty == VERDICT_70)

endmodule

bind beacon_duty_vote_classifier bdv_chk u_bdv_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
